// ===== hw/rtl/pcmm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmm_pkg
// Shared types, constants and Q16.16 helper functions for the multi-mode PID.
// ----------------------------------------------------------------------------
package pcmm_pkg;

  localparam logic [31:0] DT_GUARD_INIT = 32'd66;
  localparam logic [16:0] Q_ONE         = 17'd65536;
  // Reciprocal of ten scaled by 2^25 and rounded up; exact for dividends below 2^22.
  localparam logic [21:0] GUARD_RECIP   = 22'd3355444;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_FRATE  = 3'd4;
  localparam logic [2:0] REG_ILIM   = 3'd5;
  localparam logic [2:0] REG_DB_STA = 3'd6;
  localparam logic [2:0] REG_DB_END = 3'd7;

  // Operating modes held in the low two bits of mode_select.
  localparam logic [1:0] MODE_POS = 2'd0;
  localparam logic [1:0] MODE_INC = 2'd1;

  typedef struct packed {
    logic               start;
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    if (x > 68'sd2147483647) return S32_MAX;
    else if (x < -68'sd2147483648) return S32_MIN;
    else return x[31:0];
  endfunction

  // Product divided by 65536, truncated toward zero.
  function automatic logic signed [49:0] qtrunc(input logic signed [65:0] p);
    logic signed [65:0] adj;
    adj = p + (p[65] ? 66'sd65535 : 66'sd0);
    return adj[65:16];
  endfunction

  function automatic logic signed [31:0] mulq(input logic signed [65:0] p);
    return sat32(68'(qtrunc(p)));
  endfunction

  // Signed saturation of a sign and magnitude pair.
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    if (!neg) return (mag > 64'd2147483647) ? S32_MAX : signed'(mag[31:0]);
    else return (mag > 64'd2147483648) ? S32_MIN : signed'(32'd0 - mag[31:0]);
  endfunction

  function automatic logic signed [31:0] clamp_abs(input logic signed [31:0] x,
                                                   input logic [30:0] lim);
    logic signed [31:0] l;
    l = signed'({1'b0, lim});
    if (x > l) return l;
    else if (x < -l) return -l;
    else return x;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
    return (x == S32_MIN) ? S32_MAX : -x;
  endfunction

endpackage

// ===== hw/rtl/pcmm_mul.sv =====
// ----------------------------------------------------------------------------
// pcmm_mul
// Shared signed 33 by 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module pcmm_mul
  import pcmm_pkg::*;
(
  input  logic               clk,
  input  mul_req_t           req,
  output logic signed [65:0] prod
);

  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r <= req.a * req.b;
    end
  end

  assign prod = prod_r;

endmodule

// ===== hw/rtl/pcmm_div.sv =====
// ----------------------------------------------------------------------------
// pcmm_div
// Unsigned restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcmm_div
  import pcmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [63:0] quo_r;
  logic [31:0] dvs_r;
  logic [32:0] sh;
  logic        fit;

  assign sh  = {rem_r, quo_r[63]};
  assign fit = sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fit ? 32'(sh - {1'b0, dvs_r}) : sh[31:0];
        quo_r <= {quo_r[62:0], fit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/pid_controller_multi_mode.sv =====
// ----------------------------------------------------------------------------
// pid_controller_multi_mode
// Positional, incremental and accumulating PID in Q16.16 with a filtered
// derivative, time step guard, output clamp and deadband ramp.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / fields                        | tuser
//  in_     | slave     | target, measured, step_time, call_lim | req_type
//  out_    | master    | control_out, error_out                | -
//  cfg_    | slave     | cfg_addr register index, cfg_data     | -
//
// A compute request steps through the guard, filter, integral, derivative and sum
// states, and a deadband ramp division when active; the shared divider's passes dominate.
// A clear request gives its result on the next cycle.
// in_tready is high only while idle; a result waits in the output register,
// and the block is idle again in the cycle after the result is taken.
// Reset is synchronous on rst_n; cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_controller_multi_mode
  import pcmm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // target, measured, step_time, call_limit, zeros
  input  logic [0:0]   in_tuser,  // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // control_out, error_out
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_GMUL1, S_GREM, S_GMUL2, S_GFIN, S_FMUL, S_FSUM, S_IMUL1, S_IMUL2,
    S_IMUL3, S_ISUM, S_DDIV, S_DWAIT, S_DMUL, S_PMUL, S_SUM, S_POST, S_DBCHK,
    S_DBMUL, S_DBDIV, S_DBWAIT, S_OUT
  } state_t;

  state_t state_r;

  logic [2:0]         mode_r;
  logic signed [31:0] kp_r, ki_r, kd_r;
  logic [16:0]        rate_r;
  logic [30:0]        ilim_r, dbs_r, dbe_r;

  logic signed [31:0] err_r, err_last_r;
  logic signed [31:0] filt_r, filt_last_r, filt_bl_r;
  logic signed [31:0] integ_r, acc_r;
  logic [31:0]        dt_r, guard_r;
  logic [30:0]        lim_r;
  logic signed [31:0] t_r, iterm_r, dq_r, dterm_r, pterm_r, res_r;
  logic [14:0]        g_quo_r;
  logic [3:0]         g_rem_r;
  logic [63:0]        out_tdata_r;
  logic               out_tvalid_r;

  mul_req_t           mul_req;
  div_req_t           div_req;
  logic signed [65:0] mul_p;
  logic               div_done;
  logic [63:0]        div_q;

  pcmm_mul u_mul (.clk(clk), .req(mul_req), .prod(mul_p));
  pcmm_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done),
                  .quotient(div_q));

  logic               accept;
  logic               pos_mode;
  logic [16:0]        rate_eff;
  logic [30:0]        step_in;
  logic [31:0]        dt0;
  logic [35:0]        ten_g;
  logic [34:0]        g_sum;
  logic [17:0]        g_rem;
  logic signed [31:0] err_in;
  logic signed [34:0] diff;
  logic [34:0]        diff_mag;
  logic signed [31:0] integ_sum;
  logic signed [31:0] res_post, acc_post;
  logic signed [32:0] ae;
  logic signed [32:0] span;
  logic [65:0]        db_mag;

  assign accept   = in_tvalid && in_tready;
  assign pos_mode = mode_r[1:0] == MODE_POS;
  assign rate_eff = (rate_r > Q_ONE) ? Q_ONE : rate_r;
  assign step_in  = in_tdata[94:64];
  assign dt0      = (step_in == 31'd0) ? 32'd1 : {1'b0, step_in};
  assign ten_g    = {1'b0, guard_r, 3'b000} + {3'b000, guard_r, 1'b0};
  assign err_in   = sat32(68'(signed'(in_tdata[31:0])) - 68'(signed'(in_tdata[63:32])));

  // The guard update (9 * guard + dt) / 10 is a two-digit long division: the
  // bits from 17 upward are divided by a reciprocal multiplication first, and their
  // remainder is carried into the division of the lower 17 bits.
  assign g_sum = 35'(({4'b0, guard_r} << 3) + {4'b0, guard_r} + {4'b0, dt_r});
  assign g_rem = g_sum[34:17] - {mul_p[39:25], 3'b000} - {2'b00, mul_p[39:25], 1'b0};

  always_comb begin
    if (pos_mode) diff = 35'(filt_r) - 35'(filt_last_r);
    else diff = 35'(filt_r) - (35'(filt_last_r) <<< 1) + 35'(filt_bl_r);
    diff_mag  = diff[34] ? 35'(-diff) : 35'(diff);
    integ_sum = sat32(68'(integ_r) + 68'(iterm_r));
    if (ilim_r != 31'd0) integ_sum = clamp_abs(integ_sum, ilim_r);
    acc_post = sat32(68'(acc_r) + 68'(res_r));
    if (lim_r != 31'd0) acc_post = clamp_abs(acc_post, lim_r);
    if (mode_r[1] == 1'b0) begin
      res_post = mode_r[2] ? neg_sat(res_r) : res_r;
      if (lim_r != 31'd0) res_post = clamp_abs(res_post, lim_r);
    end else begin
      res_post = mode_r[2] ? neg_sat(acc_post) : acc_post;
    end
    ae     = err_r[31] ? -33'(err_r) : 33'(err_r);
    span   = ae - signed'({2'b00, dbs_r});
    db_mag = mul_p[65] ? 66'(-mul_p) : 66'(mul_p);
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_r)
      S_GMUL1: begin
        mul_req.start = 1'b1;
        mul_req.a     = signed'({15'b0, g_sum[34:17]});
        mul_req.b     = signed'({11'b0, GUARD_RECIP});
      end
      S_GMUL2: begin
        mul_req.start = 1'b1;
        mul_req.a     = signed'({12'b0, g_rem_r, g_sum[16:0]});
        mul_req.b     = signed'({11'b0, GUARD_RECIP});
      end
      S_FMUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = 33'(err_r) - 33'(filt_r);
        mul_req.b     = signed'({16'b0, rate_eff});
      end
      S_IMUL1: begin
        mul_req.start = 1'b1;
        mul_req.a     = 33'(ki_r);
        mul_req.b     = 33'(err_r);
      end
      S_IMUL3: begin
        mul_req.start = 1'b1;
        mul_req.a     = 33'(t_r);
        mul_req.b     = signed'({1'b0, dt_r});
      end
      S_DDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {13'b0, diff_mag, 16'b0};
        div_req.divisor  = dt_r;
      end
      S_DMUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = 33'(kd_r);
        mul_req.b     = 33'(dq_r);
      end
      S_PMUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = 33'(kp_r);
        mul_req.b     = pos_mode ? 33'(err_r)
                                 : 33'(sat32(68'(err_r) - 68'(err_last_r)));
      end
      S_DBMUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = 33'(res_r);
        mul_req.b     = span;
      end
      S_DBDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = db_mag[63:0];
        div_req.divisor  = {1'b0, dbe_r} - {1'b0, dbs_r};
      end
      default: begin
        mul_req = '0;
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      rate_r <= Q_ONE;
      ilim_r <= '0;
      dbs_r  <= '0;
      dbe_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_MODE:   mode_r <= cfg_data[2:0];
        REG_GAIN_P: kp_r   <= signed'(cfg_data);
        REG_GAIN_I: ki_r   <= signed'(cfg_data);
        REG_GAIN_D: kd_r   <= signed'(cfg_data);
        REG_FRATE:  rate_r <= cfg_data[16:0];
        REG_ILIM:   ilim_r <= cfg_data[30:0];
        REG_DB_STA: dbs_r  <= cfg_data[30:0];
        REG_DB_END: dbe_r  <= cfg_data[30:0];
        default:    mode_r <= mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      integ_r      <= '0;
      err_last_r   <= '0;
      filt_r       <= '0;
      filt_last_r  <= '0;
      filt_bl_r    <= '0;
      acc_r        <= '0;
      guard_r      <= DT_GUARD_INIT;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            lim_r <= in_tdata[125:95];
            if (in_tuser[0]) begin
              integ_r      <= '0;
              err_last_r   <= '0;
              filt_r       <= '0;
              filt_last_r  <= '0;
              filt_bl_r    <= '0;
              acc_r        <= '0;
              out_tdata_r  <= '0;
              out_tvalid_r <= 1'b1;
              state_r      <= S_OUT;
            end else begin
              err_r   <= err_in;
              dt_r    <= (36'(dt0) > ten_g) ? guard_r : dt0;
              state_r <= S_GMUL1;
            end
          end
        end
        S_GMUL1: state_r <= S_GREM;
        S_GREM: begin
          g_quo_r <= mul_p[39:25];
          g_rem_r <= g_rem[3:0];
          state_r <= S_GMUL2;
        end
        S_GMUL2: state_r <= S_GFIN;
        S_GFIN: begin
          guard_r <= {g_quo_r, mul_p[41:25]};
          state_r <= S_FMUL;
        end
        S_FMUL:  state_r <= S_FSUM;
        S_FSUM: begin
          filt_r  <= sat32(68'(filt_r) + 68'(qtrunc(mul_p)));
          state_r <= S_IMUL1;
        end
        S_IMUL1: state_r <= S_IMUL2;
        S_IMUL2: begin
          t_r     <= mulq(mul_p);
          state_r <= S_IMUL3;
        end
        S_IMUL3: state_r <= S_ISUM;
        S_ISUM: begin
          iterm_r <= mulq(mul_p);
          state_r <= S_DDIV;
        end
        S_DDIV: begin
          // The integral is only carried in positional mode.
          if (pos_mode) integ_r <= integ_sum;
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            dq_r    <= sat_mag(diff[34], div_q);
            state_r <= S_DMUL;
          end
        end
        S_DMUL: state_r <= S_PMUL;
        S_PMUL: begin
          dterm_r <= mulq(mul_p);
          state_r <= S_SUM;
        end
        S_SUM: begin
          pterm_r <= mulq(mul_p);
          state_r <= S_POST;
        end
        S_POST: begin
          res_r       <= sat32(68'(pterm_r) + 68'(pos_mode ? integ_r : iterm_r)
                               + 68'(dterm_r));
          err_last_r  <= err_r;
          filt_bl_r   <= filt_last_r;
          filt_last_r <= filt_r;
          state_r     <= S_DBCHK;
        end
        S_DBCHK: begin
          // Result sign and clamping first, then the deadband decision.
          if (mode_r[1]) acc_r <= acc_post;
          res_r <= res_post;
          out_tdata_r[63:32] <= err_r;
          if (dbe_r > dbs_r && ae < signed'({2'b00, dbs_r})) begin
            out_tdata_r[31:0] <= '0;
            out_tvalid_r      <= 1'b1;
            state_r           <= S_OUT;
          end else if (dbe_r > dbs_r && ae < signed'({2'b00, dbe_r})) begin
            state_r <= S_DBMUL;
          end else begin
            out_tdata_r[31:0] <= res_post;
            out_tvalid_r      <= 1'b1;
            state_r           <= S_OUT;
          end
        end
        S_DBMUL: state_r <= S_DBDIV;
        S_DBDIV: state_r <= S_DBWAIT;
        S_DBWAIT: begin
          if (div_done) begin
            out_tdata_r[31:0] <= sat_mag(mul_p[65], div_q);
            out_tvalid_r      <= 1'b1;
            state_r           <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a result is pending");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0]) |=> (out_tvalid && out_tdata == 64'd0))
    else $error("clear request did not give a zero result");

  a_guard_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    guard_r != 32'd0)
    else $error("time step guard fell to zero");

endmodule
